// ===== design/two_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// two_pkg: shared constants and types
// Constants, arctangent table and controller/datapath command struct for the
// tracking wheel odometry block.
// ---------------------------------------------------------------------------
package two_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanCount = 24;

  localparam logic [15:0] BackOffsetRst   = 16'd1472;
  localparam logic [15:0] DistPerDegRst   = 16'd1572;

  localparam logic signed [63:0] PiQ17      = 64'sd411775;
  localparam logic signed [63:0] TwoPiQ17   = 64'sd823550;
  localparam logic signed [63:0] HalfPiQ17  = 64'sd205887;
  localparam logic signed [31:0] GainQ28    = 32'sd163008218;
  localparam logic signed [31:0] DegToRad   = 32'sd74961321;
  localparam logic signed [63:0] CompLimit  = 64'sd4294967296;
  // floor(2^40 / TwoPiQ17)
  localparam logic signed [22:0] TwoPiRecipQ40 = 23'sd1335087;

  localparam logic CfgBackOffset = 1'b0;
  localparam logic CfgDistPerDeg = 1'b1;

  localparam logic CmdSample  = 1'b0;
  localparam logic CmdSetPose = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DIST, OP_GYRO, OP_HEAD, OP_COMP, OP_QUOT, OP_REM, OP_ANGLE,
    OP_FOLD, OP_ITER, OP_GAIN, OP_ACCUM, OP_SETPOSE
  } op_t;

  typedef struct packed {
    op_t op;
    logic [4:0] step;
  } two_cmd_t;

  function automatic logic signed [17:0] atan_q17(input logic [4:0] i);
    case (i)
      5'd0:    atan_q17 = 18'sd102944;
      5'd1:    atan_q17 = 18'sd60771;
      5'd2:    atan_q17 = 18'sd32110;
      5'd3:    atan_q17 = 18'sd16299;
      5'd4:    atan_q17 = 18'sd8181;
      5'd5:    atan_q17 = 18'sd4095;
      5'd6:    atan_q17 = 18'sd2048;
      5'd7:    atan_q17 = 18'sd1024;
      5'd8:    atan_q17 = 18'sd512;
      5'd9:    atan_q17 = 18'sd256;
      5'd10:   atan_q17 = 18'sd128;
      5'd11:   atan_q17 = 18'sd64;
      5'd12:   atan_q17 = 18'sd32;
      5'd13:   atan_q17 = 18'sd16;
      5'd14:   atan_q17 = 18'sd8;
      5'd15:   atan_q17 = 18'sd4;
      5'd16:   atan_q17 = 18'sd2;
      5'd17:   atan_q17 = 18'sd1;
      5'd18:   atan_q17 = 18'sd1;
      default: atan_q17 = 18'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/tracking_wheel_odometry.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tracking_wheel_odometry: three-wheel dead-reckoning odometry
// Pose tracking from left/right/back encoders and a gyro heading.
// ---------------------------------------------------------------------------
// One transaction at a time. A sample's result is valid after the controller
// has stepped through the datapath operations, most of them in the CORDIC
// rotation loop in the datapath; a set-pose's result after its set step. The next
// transaction is accepted the cycle after the result is taken. Configuration
// writes are taken at any time and belong between transactions.
module tracking_wheel_odometry import two_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_left_deg,
  input  wire logic signed [31:0] in_right_deg,
  input  wire logic signed [31:0] in_back_deg,
  input  wire logic signed [31:0] in_gyro_heading,
  input  wire logic signed [31:0] in_new_x,
  input  wire logic signed [31:0] in_new_y,
  input  wire logic signed [31:0] in_new_heading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_heading_rad,
  output logic                    out_saturated
);

  two_cmd_t cmd;

  assign cfg_ready = 1'b1;

  two_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .out_valid, .out_ready, .cmd
  );

  two_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_take(in_valid && in_ready),
    .cfg_take(cfg_valid),
    .cfg_index, .cfg_data,
    .in_left_deg, .in_right_deg, .in_back_deg, .in_gyro_heading,
    .in_new_x, .in_new_y, .in_new_heading,
    .out_pos_x, .out_pos_y, .out_heading_rad, .out_saturated
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("result changed while stalled");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("accept did not start work");

endmodule
`default_nettype wire

// ===== design/two_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// two_ctrl: sequencer
// Walks one transaction through the datapath steps and holds the result
// until the output side takes it.
// ---------------------------------------------------------------------------
module two_ctrl import two_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_cmd,
  output logic          out_valid,
  input  wire logic     out_ready,
  output two_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_GYRO, S_HEAD, S_COMP, S_QUOT, S_REM, S_ANGLE, S_FOLD,
    S_ITER, S_GAIN, S_ACCUM, S_SET, S_OUT
  } state_t;

  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  state_t     state_r;
  logic [4:0] step_r;
  logic       set_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.step = step_r;
    case (state_r)
      S_IDLE:  cmd.op = OP_IDLE;
      S_DIST:  cmd.op = OP_DIST;
      S_GYRO:  cmd.op = OP_GYRO;
      S_HEAD:  cmd.op = OP_HEAD;
      S_COMP:  cmd.op = OP_COMP;
      S_QUOT:  cmd.op = OP_QUOT;
      S_REM:   cmd.op = OP_REM;
      S_ANGLE: cmd.op = OP_ANGLE;
      S_FOLD:  cmd.op = OP_FOLD;
      S_ITER:  cmd.op = OP_ITER;
      S_GAIN:  cmd.op = OP_GAIN;
      S_ACCUM: cmd.op = OP_ACCUM;
      S_SET:   cmd.op = OP_SETPOSE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      set_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DIST;
            set_r   <= (in_cmd == CmdSetPose);
          end
        end
        S_DIST:  state_r <= set_r ? S_SET : S_GYRO;
        S_GYRO:  state_r <= S_HEAD;
        S_HEAD:  state_r <= S_COMP;
        S_COMP:  state_r <= S_QUOT;
        S_QUOT:  state_r <= S_REM;
        S_REM:   state_r <= S_ANGLE;
        S_ANGLE: state_r <= S_FOLD;
        S_FOLD: begin
          state_r <= S_ITER;
          step_r  <= '0;
        end
        S_ITER: begin
          if (step_r == LastStep) begin
            state_r <= S_GAIN;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_GAIN:  state_r <= S_ACCUM;
        S_ACCUM: state_r <= S_OUT;
        S_SET:   state_r <= S_OUT;
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/two_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// two_dp: odometry datapath
// Distance scaling, heading conversion, CORDIC rotation and pose
// accumulation, one operation per controller command.
// ---------------------------------------------------------------------------
module two_dp import two_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire two_cmd_t           cmd,
  input  wire logic               in_take,
  input  wire logic               cfg_take,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [31:0] in_left_deg,
  input  wire logic signed [31:0] in_right_deg,
  input  wire logic signed [31:0] in_back_deg,
  input  wire logic signed [31:0] in_gyro_heading,
  input  wire logic signed [31:0] in_new_x,
  input  wire logic signed [31:0] in_new_y,
  input  wire logic signed [31:0] in_new_heading,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_heading_rad,
  output logic                    out_saturated
);

  logic [15:0] back_off_r, dpd_r;
  logic signed [31:0] l_in_r, r_in_r, b_in_r, g_in_r, nx_r, ny_r, nh_r;
  logic signed [31:0] l_r, r_r, b_r, last_l_r, last_r_r, last_b_r;
  logic signed [31:0] last_h_r, h_r, acc_x_r, acc_y_r;
  logic signed [63:0] gprod_r, dh_r, lat_r, fwd_r, x_r, y_r, z_r, ang_r;
  logic signed [15:0] quo_r;
  logic flip_r, sat_r;

  function automatic logic signed [31:0] to_dist(input logic signed [31:0] d,
                                                 input logic [15:0] k);
    logic signed [48:0] p;
    logic signed [48:0] q;
    p = d * $signed({1'b0, k});
    q = p + ((p < 0) ? 49'sd65535 : 49'sd0);
    to_dist = q[47:16];
  endfunction

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    rnd_shr = (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    if (v > lim) clamp64 = lim;
    else if (v < -lim) clamp64 = -lim;
    else clamp64 = v;
  endfunction

  logic signed [63:0] lat_c, fwd_c, sum_c, qprod_c, wrap1_c, wrap2_c;
  logic signed [63:0] h_round;
  logic signed [63:0] xs, ys, gx_c, gy_c;
  logic signed [63:0] ax, ay;

  always_comb begin
    h_round = rnd_shr(gprod_r, 8);
    lat_c = (64'(b_r) - 64'(last_b_r)) * 64'sd65536
          + rnd_shr(64'($signed(dh_r[32:0])) * 64'($signed({1'b0, back_off_r})), 8);
    fwd_c = ((64'(l_r) - 64'(last_l_r)) + (64'(r_r) - 64'(last_r_r))) * 64'sd32768;
    sum_c = 64'(last_h_r) + 64'(h_r);
    // quotient estimate is within one of floor(angle / 2pi)
    qprod_c = 64'($signed(ang_r[32:0])) * 64'(TwoPiRecipQ40);
    if (ang_r > PiQ17) wrap1_c = ang_r - TwoPiQ17;
    else if (ang_r <= -PiQ17) wrap1_c = ang_r + TwoPiQ17;
    else wrap1_c = ang_r;
    wrap2_c = (wrap1_c > PiQ17) ? wrap1_c - TwoPiQ17 : wrap1_c;
    xs = x_r >>> cmd.step;
    ys = y_r >>> cmd.step;
    gx_c = 64'($signed(x_r[34:0])) * 64'(GainQ28);
    gy_c = 64'($signed(y_r[34:0])) * 64'(GainQ28);
    ax = 64'(acc_x_r) + x_r;
    ay = 64'(acc_y_r) + y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_off_r <= BackOffsetRst;
      dpd_r      <= DistPerDegRst;
      last_l_r   <= '0;
      last_r_r   <= '0;
      last_b_r   <= '0;
      last_h_r   <= '0;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      sat_r      <= 1'b0;
    end else begin
      if (cfg_take) begin
        if (cfg_index == CfgBackOffset) back_off_r <= cfg_data;
        else dpd_r <= cfg_data;
      end
      if (in_take) begin
        l_in_r <= in_left_deg;
        r_in_r <= in_right_deg;
        b_in_r <= in_back_deg;
        g_in_r <= in_gyro_heading;
        nx_r   <= in_new_x;
        ny_r   <= in_new_y;
        nh_r   <= in_new_heading;
      end
      case (cmd.op)
        OP_DIST: begin
          l_r     <= to_dist(l_in_r, dpd_r);
          r_r     <= to_dist(r_in_r, dpd_r);
          b_r     <= to_dist(b_in_r, dpd_r);
          gprod_r <= 64'(g_in_r) * 64'(DegToRad);
        end
        OP_GYRO: begin
          if (h_round > 64'sd2147483647) h_r <= 32'sh7fffffff;
          else if (h_round < -64'sd2147483648) h_r <= 32'sh80000000;
          else h_r <= h_round[31:0];
        end
        OP_HEAD: dh_r <= 64'(h_r) - 64'(last_h_r);
        OP_COMP: begin
          lat_r <= clamp64(lat_c, CompLimit);
          fwd_r <= clamp64(fwd_c, CompLimit);
          ang_r <= sum_c;
        end
        OP_QUOT: quo_r <= qprod_c[55:40];
        OP_REM:  ang_r <= ang_r - 64'(quo_r) * TwoPiQ17;
        OP_ANGLE: ang_r <= wrap2_c;
        OP_FOLD: begin
          x_r <= lat_r;
          y_r <= fwd_r;
          flip_r <= 1'b0;
          if (ang_r > HalfPiQ17) begin
            z_r <= -(ang_r - PiQ17);
            flip_r <= 1'b1;
          end else if (ang_r < -HalfPiQ17) begin
            z_r <= -(ang_r + PiQ17);
            flip_r <= 1'b1;
          end else begin
            z_r <= -ang_r;
          end
        end
        OP_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - 64'(atan_q17(cmd.step));
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + 64'(atan_q17(cmd.step));
          end
        end
        OP_GAIN: begin
          x_r <= flip_r ? -rnd_shr(gx_c, 28) : rnd_shr(gx_c, 28);
          y_r <= flip_r ? -rnd_shr(gy_c, 28) : rnd_shr(gy_c, 28);
        end
        OP_ACCUM: begin
          sat_r <= 1'b0;
          if (ax > 64'sd2147483647) begin
            acc_x_r <= 32'sh7fffffff;
            sat_r   <= 1'b1;
          end else if (ax < -64'sd2147483648) begin
            acc_x_r <= 32'sh80000000;
            sat_r   <= 1'b1;
          end else begin
            acc_x_r <= ax[31:0];
          end
          if (ay > 64'sd2147483647) begin
            acc_y_r <= 32'sh7fffffff;
            sat_r   <= 1'b1;
          end else if (ay < -64'sd2147483648) begin
            acc_y_r <= 32'sh80000000;
            sat_r   <= 1'b1;
          end else begin
            acc_y_r <= ay[31:0];
          end
          last_h_r <= h_r;
          last_l_r <= l_r;
          last_r_r <= r_r;
          last_b_r <= b_r;
        end
        OP_SETPOSE: begin
          acc_x_r  <= nx_r;
          acc_y_r  <= ny_r;
          last_h_r <= nh_r;
          sat_r    <= 1'b0;
          last_l_r <= l_r;
          last_r_r <= r_r;
          last_b_r <= b_r;
        end
        default: ;
      endcase
    end
  end

  assign out_pos_x       = acc_x_r;
  assign out_pos_y       = acc_y_r;
  assign out_heading_rad = last_h_r;
  assign out_saturated   = sat_r;

endmodule
`default_nettype wire
